[src/rngdfa_pkg.sv]
`default_nettype none

package rngdfa_pkg;

	// field widths of the item and result words
	localparam int MODE_W     = 2;
	localparam int BYTE_W     = 8;
	localparam int STATE_W    = 10;
	localparam int EDGE_IDX_W = 12;
	localparam int BASE_W     = 12;
	localparam int COUNT_W    = 9;

	// span of the edge base field
	localparam int BASE_SPAN = 2 ** BASE_W;

	// bytes at or above this value match no edge
	localparam int ALPHABET = 256;

	// default store depths
	localparam int DEF_NUM_STATES = 1024;
	localparam int DEF_EDGE_DEPTH = 4096;

	typedef enum logic [MODE_W-1:0] {
		MODE_EDGE    = 2'd0,
		MODE_INFO    = 2'd1,
		MODE_RESTART = 2'd2,
		MODE_SCAN    = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EDGE_WR,
		S_REDUCE,
		S_INFO_RD,
		S_INFO,
		S_WALK,
		S_ACC_RD,
		S_FIN
	} ctrl_state_t;

	typedef struct packed {
		mode_t                 mode;
		logic [BYTE_W-1:0]     byte_value;
		logic [STATE_W-1:0]    state_index;
		logic [EDGE_IDX_W-1:0] edge_index;
		logic [BYTE_W-1:0]     range_start;
		logic [BYTE_W-1:0]     range_end;
		logic [STATE_W-1:0]    target_state;
		logic [BASE_W-1:0]     edge_base;
		logic [COUNT_W-1:0]    edge_count;
		logic                  accepting;
	} item_t;

	typedef struct packed {
		logic [STATE_W-1:0] current_state;
		logic               hit;
		logic               matched;
	} result_t;

	typedef struct packed {
		logic [STATE_W-1:0] target;
		logic [BYTE_W-1:0]  hi;
		logic [BYTE_W-1:0]  lo;
	} edge_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic edge_wr;
		logic info_wr;
		logic red_step;
		logic info_rd_cur;
		logic info_rd_next;
		logic walk_init;
		logic walk_step;
		logic fin;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic red_zero;
		logic walk_empty;
		logic walk_done;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

[src/rngdfa_if.sv]
`default_nettype none

interface rngdfa_in_if;
	logic                valid;
	logic                ready;
	rngdfa_pkg::item_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rngdfa_out_if;
	logic                valid;
	logic                ready;
	rngdfa_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/rngdfa_ram.sv]
`default_nettype none

module rngdfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[src/rngdfa_ctrl.sv]
`default_nettype none

module rngdfa_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	input  wire rngdfa_pkg::mode_t   item_mode,
	output logic                     item_ready,
	input  wire rngdfa_pkg::status_t st,
	output rngdfa_pkg::cmd_t         cmd
);

	import rngdfa_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.take = 1'b1;
					unique case (item_mode)
						MODE_EDGE:    state_d = S_EDGE_WR;
						MODE_INFO:    state_d = S_REDUCE;
						MODE_RESTART: state_d = S_FIN;
						MODE_SCAN:    state_d = S_INFO_RD;
						default:      state_d = S_FIN;
					endcase
				end
			end
			S_EDGE_WR: begin
				cmd.edge_wr = 1'b1;
				state_d     = S_FIN;
			end
			S_REDUCE: begin
				if (st.red_zero) begin
					cmd.info_wr = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.red_step = 1'b1;
				end
			end
			S_INFO_RD: begin
				cmd.info_rd_cur = 1'b1;
				state_d         = S_INFO;
			end
			S_INFO: begin
				cmd.walk_init = 1'b1;
				state_d       = st.walk_empty ? S_ACC_RD : S_WALK;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (st.walk_done) begin
					state_d = S_ACC_RD;
				end
			end
			S_ACC_RD: begin
				cmd.info_rd_next = 1'b1;
				state_d          = S_FIN;
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[src/rngdfa_dp.sv]
`default_nettype none

module rngdfa_dp #(
	parameter int NUM_STATES = rngdfa_pkg::DEF_NUM_STATES,
	parameter int EDGE_DEPTH = rngdfa_pkg::DEF_EDGE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rngdfa_pkg::item_t item_data,
	input  wire rngdfa_pkg::cmd_t  cmd,
	output rngdfa_pkg::status_t    st,
	input  wire logic              res_ready,
	output logic                   res_valid,
	output rngdfa_pkg::result_t    res_data
);

	import rngdfa_pkg::*;

	localparam int SAW       = $clog2(NUM_STATES);
	localparam int EAW       = $clog2(EDGE_DEPTH);
	// quotient bits of a base reduced modulo the edge depth
	localparam int RED_STEPS = (EDGE_DEPTH >= BASE_SPAN) ? 0
		: $clog2(((BASE_SPAN - 1) / EDGE_DEPTH) + 1);
	localparam int RED_SH    = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
	localparam int CW        = EAW + RED_STEPS + 1;
	localparam int RCW       = $clog2(RED_STEPS + 2);
	localparam logic [CW-1:0] DIV_INIT = CW'(EDGE_DEPTH) << RED_SH;
	localparam logic [EAW-1:0] SLOT_LAST = EAW'(EDGE_DEPTH - 1);

	typedef struct packed {
		logic               accepting;
		logic [COUNT_W-1:0] count;
		logic [EAW-1:0]     base;
	} info_t;

	item_t              item_q;
	logic [STATE_W-1:0] scan_q;
	logic               match_q;
	logic [STATE_W-1:0] next_q;
	logic [EAW-1:0]     slot_q;
	logic [COUNT_W-1:0] left_q;
	logic               pend_q;
	logic               info_ok_q;
	logic [CW-1:0]      red_q;
	logic [CW-1:0]      dv_q;
	logic [RCW-1:0]     red_cnt_q;
	logic               res_valid_q;
	result_t            res_q;

	logic               edge_we;
	logic               edge_re;
	edge_t              edge_wd;
	edge_t              edge_rd;
	logic               info_we;
	logic               info_re;
	info_t              info_wd;
	info_t              info_rd;
	info_t              info_eff;
	logic [STATE_W-1:0] info_rd_state;
	logic               byte_ok;
	logic               edge_hit;
	logic               hit;
	logic [STATE_W-1:0] scan_new;
	logic               match_new;

	// stores
	assign edge_we = cmd.edge_wr && (32'(item_q.edge_index) < EDGE_DEPTH);
	assign edge_re = cmd.walk_step && (left_q != '0);
	assign edge_wd = '{target: item_q.target_state, hi: item_q.range_end,
		lo: item_q.range_start};

	rngdfa_ram #(
		.WIDTH ($bits(edge_t)),
		.DEPTH (EDGE_DEPTH)
	) u_edge_ram (
		.clk     (clk),
		.wr_en   (edge_we),
		.wr_addr (EAW'(item_q.edge_index)),
		.wr_data (edge_wd),
		.rd_en   (edge_re),
		.rd_addr (slot_q),
		.rd_data (edge_rd)
	);

	assign info_we       = cmd.info_wr && (32'(item_q.state_index) < NUM_STATES);
	assign info_re       = cmd.info_rd_cur || cmd.info_rd_next;
	assign info_rd_state = cmd.info_rd_next ? next_q : scan_q;
	assign info_wd       = '{accepting: item_q.accepting, count: item_q.edge_count,
		base: EAW'(red_q)};

	rngdfa_ram #(
		.WIDTH ($bits(info_t)),
		.DEPTH (NUM_STATES)
	) u_info_ram (
		.clk     (clk),
		.wr_en   (info_we),
		.wr_addr (SAW'(item_q.state_index)),
		.wr_data (info_wd),
		.rd_en   (info_re),
		.rd_addr (SAW'(info_rd_state)),
		.rd_data (info_rd)
	);

	// a state beyond the table reads as an empty, non-accepting list
	assign info_eff = info_ok_q ? info_rd : '0;
	assign byte_ok  = 9'(item_q.byte_value) < 9'(ALPHABET);
	assign edge_hit = (item_q.byte_value >= edge_rd.lo) && (item_q.byte_value <= edge_rd.hi);

	assign hit       = (item_q.mode == MODE_SCAN) && info_eff.accepting;
	always_comb begin
		unique case (item_q.mode)
			MODE_RESTART: begin
				scan_new  = '0;
				match_new = 1'b0;
			end
			MODE_SCAN: begin
				scan_new  = next_q;
				match_new = match_q | hit;
			end
			default: begin
				scan_new  = scan_q;
				match_new = match_q;
			end
		endcase
	end

	// status
	assign st.red_zero   = (red_cnt_q == '0);
	assign st.walk_empty = !byte_ok || (info_eff.count == '0);
	assign st.walk_done  = (pend_q && edge_hit) || (left_q == '0);
	assign st.out_free   = !res_valid_q || res_ready;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q    <= item_data;
			red_q     <= CW'(item_data.edge_base);
			dv_q      <= DIV_INIT;
			red_cnt_q <= RCW'(RED_STEPS);
		end
		if (cmd.red_step) begin
			if (red_q >= dv_q) begin
				red_q <= red_q - dv_q;
			end
			dv_q      <= dv_q >> 1;
			red_cnt_q <= red_cnt_q - 1'b1;
		end
		if (info_re) begin
			info_ok_q <= (32'(info_rd_state) < NUM_STATES);
		end
		if (cmd.walk_init) begin
			slot_q <= info_eff.base;
			left_q <= byte_ok ? info_eff.count : '0;
			next_q <= '0;
		end
		if (cmd.walk_step) begin
			if (left_q != '0) begin
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
				left_q <= left_q - 1'b1;
			end
			if (pend_q && edge_hit) begin
				next_q <= edge_rd.target;
			end
		end
		if (cmd.fin) begin
			res_q <= '{current_state: scan_new, hit: hit, matched: match_new};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			match_q     <= 1'b0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.walk_init) begin
				pend_q <= 1'b0;
			end else if (cmd.walk_step) begin
				pend_q <= (left_q != '0);
			end
			if (cmd.fin) begin
				scan_q      <= scan_new;
				match_q     <= match_new;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire

[src/range_compressed_dfa_matcher_top.sv]
// channel   role     handshake      word
// item      sink     valid/ready    mode, byte, edge and state-info load fields
// result    source   valid/ready    current_state, hit, matched
//
// a scanned byte reads the current state's info, walks its edge list up to
// the first matching edge (the whole list when none matches), then reads
// the next state's info; an empty list or a byte outside the alphabet skips
// the walk; a state-info load runs the modulo steps that fold the edge base
// into the edge store (none at the default depth) before it is written;
// the edge walk reads one slot of the edge memory per cycle
// reset clears the scanner state, the sticky flag and the output valid flag;
// both stores keep whatever they held
// results sit in an output register, so a new word is taken while the last
// result waits for the sink

`default_nettype none

module range_compressed_dfa_matcher_top #(
	parameter int NUM_STATES = rngdfa_pkg::DEF_NUM_STATES,
	parameter int EDGE_DEPTH = rngdfa_pkg::DEF_EDGE_DEPTH
) (
	input wire logic    clk,
	input wire logic    arst_n,
	rngdfa_in_if.sink   item,
	rngdfa_out_if.source result
);

	import rngdfa_pkg::*;

	// command and status between sequencer and datapath
	cmd_t    cmd;
	status_t st;
	logic    item_ready;
	logic    res_valid;
	result_t res_data;

	// sequencer: one word at a time, walks the edge list a slot per cycle
	rngdfa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_mode  (item.data.mode),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	// datapath: both stores, scanner state and the output register
	rngdfa_dp #(
		.NUM_STATES (NUM_STATES),
		.EDGE_DEPTH (EDGE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_data (item.data),
		.cmd       (cmd),
		.st        (st),
		.res_ready (result.ready),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	// channel hookup
	assign item.ready   = item_ready;
	assign result.valid = res_valid;
	assign result.data  = res_data;

endmodule

`default_nettype wire
